[rtl/rfrq_pkg.sv]
// Shared constants of the receive frame ring queue.
package rfrq_pkg;

   // Default sizing
   localparam int QUEUE_SLOTS_DEF = 16;
   localparam int FRAME_BYTES_DEF = 2048;

   // Fixed field widths
   localparam int BYTE_W    = 8;
   localparam int DEV_W     = 4;
   localparam int OUT_LEN_W = 12;
   localparam int STATUS_W  = 3;
   localparam int CNT_W     = 32;

   // Operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TRUNC  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DROP   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_READ   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

endpackage

[rtl/rx_frame_ring_queue.sv]
// Receive frame ring queue with tail drop: top level.
//
// Usage
//   Command channel: an item is taken when start is high and busy is low.
//   req_opcode selects push (one frame byte, with device tag and last flag)
//   or pop (one byte of the oldest committed frame).
//   Result channel: rsp_valid is high for exactly one cycle per item and
//   carries status, the popped byte with its frame length, tag and last mark,
//   and the three running frame counters (queued, dropped, delivered).
//   The receiver cannot hold a result off; it must take it in that cycle.
// Item flow
//   An item is accepted into the pending register; busy stays high in its
//   work cycle and its result is registered at the end of it, so no new
//   item is taken before then. Pops need the work cycle for the registered
//   reads of both RAMs; pushes share it to keep the pointer update in one place.
// Storage
//   Frame bytes live in one RAM of QUEUE_SLOTS*FRAME_BYTES entries; length
//   and tag of each slot in a small RAM written when a frame commits.
//   Neither RAM is cleared: only committed bytes are ever read back.
// Reset
//   Synchronous, active high. Pointers, offsets, frame flags and counters
//   go to zero; the ring is empty and the block is ready the next cycle.
module rx_frame_ring_queue #(
   parameter int QUEUE_SLOTS = rfrq_pkg::QUEUE_SLOTS_DEF,
   parameter int FRAME_BYTES = rfrq_pkg::FRAME_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // command channel
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_opcode,
   input  logic [rfrq_pkg::BYTE_W-1:0]    req_in_byte,
   input  logic [rfrq_pkg::DEV_W-1:0]     req_in_device,
   input  logic                           req_in_last,
   // result channel
   output logic                           rsp_valid,
   output logic [rfrq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [rfrq_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic [rfrq_pkg::DEV_W-1:0]     rsp_out_device,
   output logic [rfrq_pkg::OUT_LEN_W-1:0] rsp_out_length,
   output logic                           rsp_out_last,
   output logic [rfrq_pkg::CNT_W-1:0]     rsp_queued_count,
   output logic [rfrq_pkg::CNT_W-1:0]     rsp_dropped_count,
   output logic [rfrq_pkg::CNT_W-1:0]     rsp_delivered_count
);

   localparam int SLOT_W  = $clog2(QUEUE_SLOTS);
   localparam int OFF_W   = $clog2(FRAME_BYTES);
   localparam int LEN_W   = $clog2(FRAME_BYTES + 1);
   localparam int STORE_D = QUEUE_SLOTS * FRAME_BYTES;
   localparam int ADDR_W  = $clog2(STORE_D);
   localparam int META_W  = LEN_W + rfrq_pkg::DEV_W;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_SLOTS - 1);
   localparam logic [LEN_W-1:0]  FRAME_LEN = LEN_W'(FRAME_BYTES);

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   logic                          pending_ff;
   logic                          op_ff;
   logic [rfrq_pkg::BYTE_W-1:0]   byte_ff;
   logic [rfrq_pkg::DEV_W-1:0]    dev_ff;
   logic                          last_ff;

   logic [SLOT_W-1:0]             read_slot_ff,   read_slot_in;
   logic [SLOT_W-1:0]             write_slot_ff,  write_slot_in;
   logic [LEN_W-1:0]              write_off_ff,   write_off_in;
   logic [OFF_W-1:0]              read_off_ff,    read_off_in;
   logic                          in_frame_ff,    in_frame_in;
   logic                          dropping_ff,    dropping_in;
   logic [rfrq_pkg::DEV_W-1:0]    cur_dev_ff,     cur_dev_in;
   logic [rfrq_pkg::CNT_W-1:0]    queued_ff,      queued_in;
   logic [rfrq_pkg::CNT_W-1:0]    dropped_ff,     dropped_in;
   logic [rfrq_pkg::CNT_W-1:0]    delivered_ff,   delivered_in;

   logic                          rsp_valid_ff;
   logic [rfrq_pkg::STATUS_W-1:0] status_ff,      status_in;
   logic [rfrq_pkg::BYTE_W-1:0]   out_byte_ff,    out_byte_in;
   logic [rfrq_pkg::DEV_W-1:0]    out_dev_ff,     out_dev_in;
   logic [rfrq_pkg::OUT_LEN_W-1:0] out_len_ff,    out_len_in;
   logic                          out_last_ff,    out_last_in;

   logic                          accept;

   // memory ports
   logic                          st_wr_en;
   logic [ADDR_W-1:0]             st_wr_addr;
   logic                          st_rd_en;
   logic [ADDR_W-1:0]             st_rd_addr;
   logic [rfrq_pkg::BYTE_W-1:0]   st_rd_data;
   logic                          meta_wr_en;
   logic [META_W-1:0]             meta_wr_data;
   logic [META_W-1:0]             meta_rd_data;

   // push-side helpers
   logic [SLOT_W-1:0]             next_write;
   logic [SLOT_W-1:0]             next_read;
   logic                          ring_full;
   logic                          ring_empty;
   logic                          first_byte;
   logic                          drop_now;
   logic [LEN_W-1:0]              off_now;
   logic [LEN_W-1:0]              off_after;
   logic [rfrq_pkg::DEV_W-1:0]    dev_now;

   // pop-side helpers
   logic [LEN_W-1:0]              head_len;
   logic [rfrq_pkg::DEV_W-1:0]    head_dev;
   logic                          head_last;

   assign accept = start && !busy;
   assign busy   = pending_ff;

   // ---------------------------------------------------------------------
   // Memories
   // ---------------------------------------------------------------------
   // Pop reads are issued from the pointer registers at the accept edge, so
   // the data is ready in the following (work) cycle.
   assign st_rd_en   = accept && (req_opcode == rfrq_pkg::OP_POP);
   assign st_rd_addr = ADDR_W'(read_slot_ff) * ADDR_W'(FRAME_BYTES) + ADDR_W'(read_off_ff);

   rfrq_ram #(
      .DATA_W (rfrq_pkg::BYTE_W),
      .DEPTH  (STORE_D)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (byte_ff),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // Slot table: {length, device}, written when a frame commits.
   rfrq_ram #(
      .DATA_W (META_W),
      .DEPTH  (QUEUE_SLOTS)
   ) u_slot_table (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (write_slot_ff),
      .wr_data (meta_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (read_slot_ff),
      .rd_data (meta_rd_data)
   );

   // ---------------------------------------------------------------------
   // Work cycle
   // ---------------------------------------------------------------------
   assign next_write = (write_slot_ff == LAST_SLOT) ? '0 : write_slot_ff + 1'b1;
   assign next_read  = (read_slot_ff == LAST_SLOT)  ? '0 : read_slot_ff + 1'b1;
   assign ring_full  = (next_write == read_slot_ff);
   assign ring_empty = (read_slot_ff == write_slot_ff);

   // Fullness is only judged at a frame's first byte.
   assign first_byte = !in_frame_ff;
   assign drop_now   = first_byte ? ring_full : dropping_ff;
   assign off_now    = first_byte ? '0 : write_off_ff;
   assign dev_now    = first_byte ? dev_ff : cur_dev_ff;

   assign head_len  = meta_rd_data[META_W-1 -: LEN_W];
   assign head_dev  = meta_rd_data[rfrq_pkg::DEV_W-1:0];
   assign head_last = (LEN_W'(read_off_ff) + 1'b1) >= head_len;

   assign st_wr_addr = ADDR_W'(write_slot_ff) * ADDR_W'(FRAME_BYTES)
                     + ADDR_W'(off_now[OFF_W-1:0]);
   assign meta_wr_data = {off_after, dev_now};

   always_comb begin
      read_slot_in  = read_slot_ff;
      write_slot_in = write_slot_ff;
      write_off_in  = write_off_ff;
      read_off_in   = read_off_ff;
      in_frame_in   = in_frame_ff;
      dropping_in   = dropping_ff;
      cur_dev_in    = cur_dev_ff;
      queued_in     = queued_ff;
      dropped_in    = dropped_ff;
      delivered_in  = delivered_ff;
      status_in     = rfrq_pkg::ST_EMPTY;
      out_byte_in   = '0;
      out_dev_in    = '0;
      out_len_in    = '0;
      out_last_in   = 1'b0;
      st_wr_en      = 1'b0;
      meta_wr_en    = 1'b0;
      off_after     = off_now;

      if (pending_ff) begin
         if (op_ff == rfrq_pkg::OP_PUSH) begin
            if (first_byte && ring_full) begin
               dropped_in = dropped_ff + 1'b1;
            end
            if (drop_now) begin
               status_in = rfrq_pkg::ST_DROP;
            end else if (off_now < FRAME_LEN) begin
               st_wr_en  = 1'b1;
               off_after = off_now + 1'b1;
               status_in = rfrq_pkg::ST_STORED;
            end else begin
               // oversize: byte discarded, frame kept
               status_in = rfrq_pkg::ST_TRUNC;
            end
            if (last_ff) begin
               if (!drop_now) begin
                  meta_wr_en    = 1'b1;
                  write_slot_in = next_write;
                  queued_in     = queued_ff + 1'b1;
               end
               in_frame_in  = 1'b0;
               dropping_in  = 1'b0;
               write_off_in = '0;
            end else begin
               in_frame_in  = 1'b1;
               dropping_in  = drop_now;
               write_off_in = drop_now ? write_off_ff : off_after;
               cur_dev_in   = dev_now;
            end
         end else if (!ring_empty) begin
            status_in   = rfrq_pkg::ST_READ;
            out_byte_in = st_rd_data;
            out_dev_in  = head_dev;
            out_len_in  = rfrq_pkg::OUT_LEN_W'(head_len);
            if (head_last) begin
               out_last_in  = 1'b1;
               read_off_in  = '0;
               read_slot_in = next_read;
               delivered_in = delivered_ff + 1'b1;
            end else begin
               read_off_in = read_off_ff + 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         read_slot_ff  <= '0;
         write_slot_ff <= '0;
         write_off_ff  <= '0;
         read_off_ff   <= '0;
         in_frame_ff   <= 1'b0;
         dropping_ff   <= 1'b0;
         queued_ff     <= '0;
         dropped_ff    <= '0;
         delivered_ff  <= '0;
      end else begin
         pending_ff    <= accept;
         rsp_valid_ff  <= pending_ff;
         read_slot_ff  <= read_slot_in;
         write_slot_ff <= write_slot_in;
         write_off_ff  <= write_off_in;
         read_off_ff   <= read_off_in;
         in_frame_ff   <= in_frame_in;
         dropping_ff   <= dropping_in;
         queued_ff     <= queued_in;
         dropped_ff    <= dropped_in;
         delivered_ff  <= delivered_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_opcode;
         byte_ff <= req_in_byte;
         dev_ff  <= req_in_device;
         last_ff <= req_in_last;
      end
      cur_dev_ff <= cur_dev_in;
      if (pending_ff) begin
         status_ff   <= status_in;
         out_byte_ff <= out_byte_in;
         out_dev_ff  <= out_dev_in;
         out_len_ff  <= out_len_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_out_byte        = out_byte_ff;
   assign rsp_out_device      = out_dev_ff;
   assign rsp_out_length      = out_len_ff;
   assign rsp_out_last        = out_last_ff;
   assign rsp_queued_count    = queued_ff;
   assign rsp_dropped_count   = dropped_ff;
   assign rsp_delivered_count = delivered_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_one_result_per_item: assert property (@(posedge clock) disable iff (reset)
      pending_ff |=> (rsp_valid_ff && !pending_ff))
      else $error("item in work did not give exactly one result");

   a_no_accept_back_to_back: assert property (@(posedge clock) disable iff (reset)
      accept |=> !accept)
      else $error("item accepted while previous still in work");

   a_drop_only_in_frame: assert property (@(posedge clock) disable iff (reset)
      dropping_ff |-> in_frame_ff)
      else $error("drop flag set outside a frame");

   a_write_off_bound: assert property (@(posedge clock) disable iff (reset)
      write_off_ff <= FRAME_LEN)
      else $error("write offset beyond frame size");

endmodule

[rtl/rfrq_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
module rfrq_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 32768,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
